### hdl/snt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snt_pkg: shared constants and helpers of the sigmoid neuron trainer
// Holds the Q4.12 formats, operation codes and the sigmoid curve lookup.
// ----------------------------------------------------------------------------
package snt_pkg;

    localparam int NumWeightsDef   = 16;
    localparam int SigTableDepthDef = 256;
    localparam logic [15:0] LrReset = 16'd655;

    localparam logic [1:0] OpLoad    = 2'd0;
    localparam logic [1:0] OpForward = 2'd1;
    localparam logic [1:0] OpTrain   = 2'd2;
    localparam logic [1:0] OpAdjust  = 2'd3;

    localparam logic KindAct   = 1'b0;
    localparam logic KindNudge = 1'b1;

    // Piecewise sigmoid of the bucket's low edge; bucket has cw bits.
    function automatic logic signed [15:0] sigmoid_cell(input logic [11:0] bucket,
                                                        input int cw);
        logic [16:0] sh;
        logic signed [16:0] xs;
        logic [16:0] ax;
        logic [16:0] y;
        begin
            sh = 17'({5'd0, bucket} << (16 - cw));
            xs = $signed(sh) - 17'sd32768;
            ax = xs[16] ? 17'(-xs) : 17'(xs);
            if (ax >= 17'd20480)      y = 17'd4096;
            else if (ax >= 17'd9728)  y = (ax >> 5) + 17'd3456;
            else if (ax >= 17'd4096)  y = (ax >> 3) + 17'd2560;
            else                      y = (ax >> 2) + 17'd2048;
            if (xs[16]) y = 17'd4096 - y;
            sigmoid_cell = $signed(y[15:0]);
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        begin
            if (v > 48'sd32767)       sat16 = 16'sh7fff;
            else if (v < -48'sd32768) sat16 = 16'sh8000;
            else                      sat16 = v[15:0];
        end
    endfunction

endpackage

### hdl/snt_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snt_divider: signed 32 / unsigned 16 divider, one quotient bit per cycle
// Quotient truncates toward zero, like the mean of a gradient sum.
// ----------------------------------------------------------------------------
module snt_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic [15:0]        divisor,
    output logic               done,
    output logic signed [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic [15:0] d_reg, d_next;
    logic [16:0] trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; cnt_next = cnt_reg; neg_next = neg_reg;
        busy_next = busy_reg; d_next = d_reg; done = 1'b0;
        trial = {r_reg[15:0], q_reg[31]};
        if (start) begin
            // take magnitude; -2^31 magnitude fits 32 unsigned bits
            q_next = dividend[31] ? 32'(-dividend) : 32'(dividend);
            neg_next = dividend[31];
            r_next = '0; cnt_next = '0; busy_next = 1'b1; d_next = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    always_comb begin
        quotient = neg_reg ? $signed(-q_next) : $signed(q_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; neg_reg <= neg_next; d_reg <= d_next;
    end
endmodule

### hdl/sigmoid_neuron_trainer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigmoid_neuron_trainer: one sigmoid neuron with batch gradient descent
// Q4.12 forward pass, gradient accumulation and weight adjust over memories.
// ----------------------------------------------------------------------------
// Steps: a load is taken in the idle state; a forward/train element that is
// not last reads its weight memory entry, then multiply-accumulates, or is
// dropped when it falls past the last weight. A last element then computes
// the activation; a train last then walks the NUM_WEIGHTS entries, reading
// the weight, input and gradient memories and writing back the
// gradient sum while the nudges go out. An adjust with samples walks every
// weight and the bias through a bit-serial divider. Weights, gradient sums
// and the buffered vector live in single-port synchronous memories with
// registered reads. No clearing pass is needed: weight and gradient
// entries carry valid bits cleared at reset.
// ----------------------------------------------------------------------------
module sigmoid_neuron_trainer #(
    parameter int NUM_WEIGHTS         = snt_pkg::NumWeightsDef,
    parameter int SIGMOID_TABLE_DEPTH = snt_pkg::SigTableDepthDef
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [4:0]         s_slot,
    input  logic signed [15:0] s_value,
    input  logic signed [15:0] s_target,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [3:0]         m_index,
    output logic signed [15:0] m_result_value,
    output logic               m_final_res
);
    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int PW = $clog2(NUM_WEIGHTS + 1);
    localparam int CW = $clog2(SIGMOID_TABLE_DEPTH);

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StMac   = 4'd1;
    localparam logic [3:0] StAct   = 4'd2;
    localparam logic [3:0] StGrad  = 4'd3;
    localparam logic [3:0] StTRd   = 4'd4;
    localparam logic [3:0] StTMul  = 4'd5;
    localparam logic [3:0] StTWr   = 4'd6;
    localparam logic [3:0] StARd   = 4'd7;
    localparam logic [3:0] StADiv  = 4'd8;
    localparam logic [3:0] StAMul  = 4'd9;
    localparam logic [3:0] StAWr   = 4'd10;
    localparam logic [3:0] StSig   = 4'd11;
    localparam logic [3:0] StGMul  = 4'd12;
    localparam logic [3:0] StAGo   = 4'd13;

    // memories
    logic signed [15:0] wmem [NUM_WEIGHTS];
    logic signed [31:0] gmem [NUM_WEIGHTS];
    logic signed [15:0] xmem [NUM_WEIGHTS];
    logic [NUM_WEIGHTS-1:0] wval_reg, gval_reg;
    logic signed [15:0] wrd_reg, xrd_reg;
    logic signed [31:0] grd_reg;
    logic               wrv_reg, grv_reg;

    logic [3:0]  st_reg;
    logic [15:0] lr_reg;
    logic signed [15:0] bias_reg;
    logic signed [31:0] bgs_reg;
    logic [15:0] cnt_reg;
    logic signed [39:0] dot_reg;
    logic [PW-1:0] pos_reg, used_reg;
    logic [AW-1:0] ptr_reg;
    logic        isbias_reg;
    logic signed [15:0] val_reg, tgt_reg;
    logic [1:0]  op_reg;
    logic        lastf_reg;
    logic signed [15:0] s_reg;
    logic signed [31:0] g_reg;
    logic signed [47:0] prod_reg, prod2_reg;
    logic signed [31:0] mean_reg;

    // output register
    logic        ov_reg, okind_reg, ofin_reg;
    logic [3:0]  oidx_reg;
    logic signed [15:0] oval_reg;
    logic        out_load;

    logic        div_done;
    logic signed [31:0] div_q;
    logic        div_start;

    snt_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(isbias_reg ? bgs_reg : (grv_reg ? grd_reg : 32'sd0)),
        .divisor(cnt_reg), .done(div_done), .quotient(div_q)
    );

    assign s_ready = (st_reg == StIdle);
    assign m_valid = ov_reg;
    assign m_kind = okind_reg;
    assign m_index = oidx_reg;
    assign m_result_value = oval_reg;
    assign m_final_res = ofin_reg;
    // kick the divider once per entry, with its dividend already registered
    assign div_start = (st_reg == StAGo);
    // load the output register when a result is ready and the slot is free
    assign out_load = ((st_reg == StSig) || (st_reg == StTWr)) && (!ov_reg || m_ready);

    logic signed [15:0] w_eff, x_eff;
    logic signed [47:0] zr, ge;
    logic signed [31:0] gsum;
    logic signed [48:0] gacc;
    logic signed [16:0] zc;
    logic [15:0] zu;
    logic signed [47:0] dd;
    logic signed [47:0] sb;
    logic signed [31:0] mac_p, sd_p, eg_p;
    logic signed [47:0] xg_p, wg_p, lm_p;
    logic signed [16:0] s_c;
    logic signed [18:0] e2;
    logic signed [13:0] d_q;
    logic signed [47:0] gnew;
    logic signed [48:0] bacc;
    logic signed [31:0] bsum;
    logic ptr_end;
    assign w_eff = wrv_reg ? wrd_reg : 16'sd0;
    assign x_eff = (PW'(ptr_reg) < used_reg) ? xrd_reg : 16'sd0;
    assign ptr_end = (ptr_reg == AW'(NUM_WEIGHTS - 1));

    always_comb begin
        zr = (48'(dot_reg) + (48'(bias_reg) <<< 12) + 48'sd2048) >>> 12;
        zc = (zr > 48'sd32767) ? 17'sd32767 : ((zr < -48'sd32768) ? -17'sd32768 : zr[16:0]);
        zu = 16'(zc + 17'sd32768);
        ge = (prod_reg + 48'sd2048) >>> 12;
        gacc = 49'(grv_reg ? grd_reg : 32'sd0) + 49'(ge);
        gsum = (gacc > 49'sd2147483647) ? 32'sh7fffffff :
               ((gacc < -49'sd2147483648) ? 32'sh80000000 : gacc[31:0]);
        dd = (prod2_reg + 48'sd32768) >>> 16;
        sb = 48'(isbias_reg ? bias_reg : w_eff) - dd;
        // narrow products, each sized for its operands
        mac_p = w_eff * val_reg;
        s_c = 17'sd4096 - 17'(s_reg);
        sd_p = s_reg * s_c;
        e2 = 19'(17'(s_reg) - 17'(tgt_reg)) <<< 1;
        d_q = 14'(prod_reg >>> 12);
        eg_p = e2 * d_q;
        xg_p = x_eff * g_reg;
        wg_p = w_eff * g_reg;
        lm_p = $signed({1'b0, lr_reg}) * mean_reg;
        gnew = (prod2_reg + 48'sd2048) >>> 12;
        bacc = 49'(bgs_reg) + 49'(gnew);
        bsum = (bacc > 49'sd2147483647) ? 32'sh7fffffff :
               ((bacc < -49'sd2147483648) ? 32'sh80000000 : bacc[31:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= StIdle; lr_reg <= snt_pkg::LrReset; bias_reg <= '0;
            bgs_reg <= '0; cnt_reg <= '0; dot_reg <= '0; pos_reg <= '0;
            wval_reg <= '0; gval_reg <= '0; ov_reg <= 1'b0; lastf_reg <= 1'b0;
        end else begin
            if (cfg_we) lr_reg <= cfg_wdata;
            if (out_load) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
            unique case (st_reg)
                StIdle: if (s_valid) begin
                    op_reg <= s_operation; val_reg <= s_value; tgt_reg <= s_target;
                    unique case (s_operation)
                        snt_pkg::OpLoad: begin
                            if (s_slot < 5'(NUM_WEIGHTS)) begin
                                wmem[AW'(s_slot)] <= s_value;
                                wval_reg[AW'(s_slot)] <= 1'b1;
                            end else if (s_slot == 5'(NUM_WEIGHTS)) bias_reg <= s_value;
                        end
                        snt_pkg::OpAdjust: if (cnt_reg != 0) begin
                            ptr_reg <= '0; isbias_reg <= 1'b0; st_reg <= StARd;
                        end
                        default: begin
                            lastf_reg <= s_last;
                            if (pos_reg < PW'(NUM_WEIGHTS)) begin
                                xmem[AW'(pos_reg)] <= s_value;
                                wrd_reg <= wmem[AW'(pos_reg)];
                                wrv_reg <= wval_reg[AW'(pos_reg)];
                                ptr_reg <= AW'(pos_reg);
                                pos_reg <= pos_reg + PW'(1);
                                st_reg <= StMac;
                            end else if (s_last) st_reg <= StAct;
                        end
                    endcase
                end
                StMac: begin
                    dot_reg <= dot_reg + 40'(mac_p);
                    st_reg <= lastf_reg ? StAct : StIdle;
                end
                StAct: begin
                    s_reg <= snt_pkg::sigmoid_cell(12'(zu >> (16 - CW)), CW);
                    used_reg <= pos_reg; dot_reg <= '0; pos_reg <= '0;
                    st_reg <= StSig;
                end
                StSig: if (!ov_reg || m_ready) begin
                    okind_reg <= snt_pkg::KindAct; oidx_reg <= '0;
                    oval_reg <= s_reg; ofin_reg <= (op_reg == snt_pkg::OpForward);
                    prod_reg <= 48'(sd_p);
                    st_reg <= (op_reg == snt_pkg::OpForward) ? StIdle : StGrad;
                end
                StGrad: begin
                    prod2_reg <= 48'(eg_p);
                    st_reg <= StGMul;
                end
                StGMul: begin
                    g_reg <= 32'(gnew);
                    bgs_reg <= bsum;
                    if (cnt_reg != 16'hffff) cnt_reg <= cnt_reg + 16'd1;
                    ptr_reg <= '0; st_reg <= StTRd;
                end
                StTRd: begin
                    wrd_reg <= wmem[ptr_reg]; wrv_reg <= wval_reg[ptr_reg];
                    xrd_reg <= xmem[ptr_reg];
                    grd_reg <= gmem[ptr_reg]; grv_reg <= gval_reg[ptr_reg];
                    st_reg <= StTMul;
                end
                StTMul: begin
                    prod_reg <= xg_p;
                    prod2_reg <= wg_p;
                    st_reg <= StTWr;
                end
                StTWr: if (!ov_reg || m_ready) begin
                    gmem[ptr_reg] <= gsum; gval_reg[ptr_reg] <= 1'b1;
                    okind_reg <= snt_pkg::KindNudge;
                    oidx_reg <= 4'({{(32-AW){1'b0}}, ptr_reg});
                    oval_reg <= snt_pkg::sat16((prod2_reg + 48'sd2048) >>> 12);
                    ofin_reg <= ptr_end;
                    ptr_reg <= ptr_reg + AW'(1);
                    st_reg <= ptr_end ? StIdle : StTRd;
                end
                StARd: begin
                    wrd_reg <= wmem[ptr_reg]; wrv_reg <= wval_reg[ptr_reg];
                    grd_reg <= gmem[ptr_reg]; grv_reg <= gval_reg[ptr_reg];
                    st_reg <= StAGo;
                end
                StAGo: st_reg <= StADiv;
                StADiv: if (div_done) begin
                    mean_reg <= div_q; st_reg <= StAMul;
                end
                StAMul: begin
                    prod2_reg <= lm_p;
                    st_reg <= StAWr;
                end
                StAWr: begin
                    if (isbias_reg) begin
                        bias_reg <= snt_pkg::sat16(sb);
                        bgs_reg <= '0; cnt_reg <= '0; gval_reg <= '0;
                        st_reg <= StIdle;
                    end else begin
                        wmem[ptr_reg] <= snt_pkg::sat16(sb);
                        wval_reg[ptr_reg] <= 1'b1;
                        if (ptr_end) isbias_reg <= 1'b1;
                        else ptr_reg <= ptr_reg + AW'(1);
                        st_reg <= ptr_end ? StAGo : StARd;
                    end
                end
                default: st_reg <= StIdle;
            endcase
        end
    end
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sigmoid neuron trainer
// Streams loads, forward and train vectors and adjusts through the input
// channel, predicts every activation and nudge in-bench and checks each
// result transfer in order. The rate is switched between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NW = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 1000;

    typedef struct {
        logic [1:0]         op;
        logic [4:0]         slot;
        logic signed [15:0] value;
        logic signed [15:0] target;
        logic               last;
    } neuron_item_t;

    typedef struct {
        logic               kind;
        logic [3:0]         index;
        logic signed [15:0] value;
        logic               fin;
    } neuron_result_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [15:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_operation;
    logic [4:0]         s_slot;
    logic signed [15:0] s_value;
    logic signed [15:0] s_target;
    logic               s_last;
    logic               m_valid;
    logic               m_ready;
    logic               m_kind;
    logic [3:0]         m_index;
    logic signed [15:0] m_result_value;
    logic               m_final_res;

    sigmoid_neuron_trainer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_slot         (s_slot),
        .s_value        (s_value),
        .s_target       (s_target),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_index        (m_index),
        .m_result_value (m_result_value),
        .m_final_res    (m_final_res)
    );

    // Stimulus and expected-result stores.
    neuron_item_t   pending_items[$];
    neuron_result_t expected_results[$];

    // Shadow copy of the neuron state.
    logic signed [15:0] sh_weight[NW];
    logic signed [15:0] sh_bias;
    logic signed [15:0] sh_xbuf[NW];
    int signed          sh_wgrad[NW];
    int signed          sh_bgrad;
    int                 sh_samples;
    longint             sh_dot;
    int                 sh_pos;
    logic [15:0]        sh_rate;

    int  mismatches;
    int  items_sent;
    int  items_accepted;
    int  results_checked;
    int  trains_done;
    int  adjusts_done;
    bit  quiet;
    bit  hold_go;
    int  hold_count;
    int  gap_left;
    int  stall_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------
    function automatic longint clamp64(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Round to nearest, halves toward +inf.
    function automatic longint round_down_by(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // Piecewise sigmoid of the low edge of the table bucket holding x.
    function automatic longint activation_of(input longint x);
        longint bucket, xs, ax, y;
        bucket = (x + 32768) >>> 8;
        xs = bucket * 256 - 32768;
        ax = (xs < 0) ? -xs : xs;
        if (ax >= 20480)     y = 4096;
        else if (ax >= 9728) y = (ax >>> 5) + 3456;
        else if (ax >= 4096) y = (ax >>> 3) + 2560;
        else                 y = (ax >>> 2) + 2048;
        return (xs < 0) ? 4096 - y : y;
    endfunction

    task automatic push_result(input logic kind, input int idx, input longint v,
                               input logic fin);
        neuron_result_t r;
        r.kind  = kind;
        r.index = idx[3:0];
        r.value = 16'(clamp64(v, -32768, 32767));
        r.fin   = fin;
        expected_results = {expected_results, r};
    endtask

    // Advance the shadow state by one accepted transfer, queue its results.
    task automatic apply_item(input neuron_item_t it);
        longint z, s, d, e, g, x, mean, step, lr;
        int used;
        lr = longint'({48'd0, sh_rate});
        case (it.op)
            snt_pkg::OpLoad: begin
                if (it.slot < NW) sh_weight[it.slot] = it.value;
                else if (it.slot == NW) sh_bias = it.value;
            end
            snt_pkg::OpAdjust: begin
                if (sh_samples != 0) begin
                    adjusts_done++;
                    for (int i = 0; i < NW; i++) begin
                        mean = longint'(sh_wgrad[i]) / longint'(sh_samples);
                        step = round_down_by(lr * mean, 16);
                        sh_weight[i] = 16'(clamp64(longint'(sh_weight[i]) - step,
                                                   -32768, 32767));
                        sh_wgrad[i] = 0;
                    end
                    mean = longint'(sh_bgrad) / longint'(sh_samples);
                    step = round_down_by(lr * mean, 16);
                    sh_bias = 16'(clamp64(longint'(sh_bias) - step, -32768, 32767));
                    sh_bgrad = 0;
                    sh_samples = 0;
                end
            end
            default: begin
                // Elements past the last weight are dropped, but last still counts.
                if (sh_pos < NW) begin
                    sh_xbuf[sh_pos] = it.value;
                    sh_dot += longint'(sh_weight[sh_pos]) * longint'(it.value);
                    sh_pos++;
                end
                if (it.last) begin
                    z = round_down_by(sh_dot + longint'(sh_bias) * 4096, 12);
                    s = activation_of(clamp64(z, -32768, 32767));
                    used = sh_pos;
                    sh_dot = 0;
                    sh_pos = 0;
                    if (it.op == snt_pkg::OpForward) begin
                        push_result(snt_pkg::KindAct, 0, s, 1'b1);
                    end else begin
                        trains_done++;
                        push_result(snt_pkg::KindAct, 0, s, 1'b0);
                        d = (s * (4096 - s)) >>> 12;
                        e = 2 * (s - longint'(it.target));
                        g = round_down_by(e * d, 12);
                        for (int i = 0; i < NW; i++) begin
                            x = (i < used) ? longint'(sh_xbuf[i]) : 0;
                            sh_wgrad[i] = int'(clamp64(longint'(sh_wgrad[i])
                                + round_down_by(x * g, 12), -(64'sd1 <<< 31),
                                (64'sd1 <<< 31) - 1));
                        end
                        sh_bgrad = int'(clamp64(longint'(sh_bgrad) + g, -(64'sd1 <<< 31),
                                                (64'sd1 <<< 31) - 1));
                        if (sh_samples < 65535) sh_samples++;
                        for (int i = 0; i < NW; i++)
                            push_result(snt_pkg::KindNudge, i,
                                round_down_by(longint'(sh_weight[i]) * g, 12),
                                i == NW - 1);
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: input channel, idle bursts between transfers
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        neuron_item_t it;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_operation <= snt_pkg::OpLoad;
            s_slot      <= '0;
            s_value     <= '0;
            s_target    <= '0;
            s_last      <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                it.op = s_operation;
                it.slot = s_slot;
                it.value = s_value;
                it.target = s_target;
                it.last = s_last;
                apply_item(it);
                items_accepted++;
            end
            // Only move on once the offered item is gone.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 6) == 0) begin
                    gap_left = $urandom_range(0, 3);
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= it.op;
                    s_slot      <= it.slot;
                    s_value     <= it.value;
                    s_target    <= it.target;
                    s_last      <= it.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stall bursts plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (hold_go && hold_count < HOLD_CYCLES) begin
            hold_count++;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        neuron_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result kind=%0d index=%0d value=%0d fin=%0d",
                             $realtime, m_kind, m_index, m_result_value, m_final_res);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_kind !== want.kind || m_index !== want.index ||
                    m_result_value !== want.value || m_final_res !== want.fin) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] mismatch: expected kind=%0d index=%0d value=%0d ",
                                  "fin=%0d, got kind=%0d index=%0d value=%0d fin=%0d"},
                                 $realtime, want.kind, want.index, want.value, want.fin,
                                 m_kind, m_index, m_result_value, m_final_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [1:0] op, input logic [4:0] slot,
                              input logic signed [15:0] value,
                              input logic signed [15:0] target, input logic last);
        neuron_item_t it;
        it.op = op;
        it.slot = slot;
        it.value = value;
        it.target = target;
        it.last = last;
        pending_items = {pending_items, it};
        items_sent++;
    endtask

    // Half the values stay within +-1.0 so the sigmoid is not always pinned.
    function automatic logic signed [15:0] any_q12();
        if ($urandom_range(0, 1) == 0) return 16'($signed($urandom_range(0, 8191)) - 4096);
        return 16'($urandom());
    endfunction

    task automatic queue_random(input int count);
        int stop, len, r;
        logic [1:0] vop;
        logic signed [15:0] tgt;
        stop = items_sent + count;
        while (items_sent < stop) begin
            r = $urandom_range(0, 9);
            if (r <= 1) begin
                repeat ($urandom_range(1, 4))
                    queue_item(snt_pkg::OpLoad, 5'($urandom_range(0, NW)), any_q12(),
                               16'($urandom()), 1'($urandom()));
            end else if (r <= 7) begin
                // Mostly full or short vectors, a few running past the weights.
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(NW + 1, NW + 3)
                                                  : $urandom_range(1, NW);
                vop = ($urandom_range(0, 9) < 6) ? snt_pkg::OpTrain : snt_pkg::OpForward;
                tgt = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 4096));
                for (int i = 0; i < len; i++) begin
                    if (i < len - 1 && $urandom_range(0, 9) == 0)
                        queue_item(($urandom_range(0, 1) != 0) ? snt_pkg::OpForward
                                                               : snt_pkg::OpTrain,
                                   5'($urandom()), any_q12(), 16'($urandom()), 1'b0);
                    else
                        queue_item(vop, 5'($urandom()), any_q12(), tgt, i == len - 1);
                end
            end else if (r == 8) begin
                queue_item(snt_pkg::OpAdjust, 5'($urandom()), 16'($urandom()),
                           16'($urandom()), 1'($urandom()));
            end else begin
                queue_item(2'($urandom()), 5'($urandom()), 16'($urandom()),
                           16'($urandom()), 1'($urandom()));
            end
        end
    endtask

    // Hold until everything is sent and answered, then let adjusts finish.
    task automatic settle();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_rate(input logic [15:0] rate);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        sh_rate = rate;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        quiet     = 1'b0;
        hold_go   = 1'b0;
        hold_count = 0;
        mismatches = 0;
        items_sent = 0;
        items_accepted = 0;
        results_checked = 0;
        trains_done = 0;
        adjusts_done = 0;
        for (int i = 0; i < NW; i++) begin
            sh_weight[i] = '0;
            sh_xbuf[i] = '0;
            sh_wgrad[i] = 0;
        end
        sh_bias = '0;
        sh_bgrad = 0;
        sh_samples = 0;
        sh_dot = 0;
        sh_pos = 0;
        sh_rate = snt_pkg::LrReset;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, ignored loads, empty adjust, mixed vector.
        queue_item(snt_pkg::OpLoad, 5'd0, 16'sh7fff, 16'sh0000, 1'b0);
        queue_item(snt_pkg::OpLoad, 5'd1, -16'sd32768, 16'sh7fff, 1'b1);
        queue_item(snt_pkg::OpLoad, 5'd16, 16'sd4096, -16'sd32768, 1'b0);
        queue_item(snt_pkg::OpLoad, 5'd17, 16'shffff, 16'shffff, 1'b1);
        queue_item(snt_pkg::OpLoad, 5'd31, 16'sh5555, 16'sh2aaa, 1'b0);
        queue_item(snt_pkg::OpForward, 5'd31, 16'sh7fff, 16'sh0000, 1'b0);
        queue_item(snt_pkg::OpForward, 5'd0, -16'sd32768, 16'sh0000, 1'b1);
        queue_item(snt_pkg::OpAdjust, 5'd0, 16'sh0000, 16'sh0000, 1'b0);
        queue_item(snt_pkg::OpForward, 5'd0, 16'sd2048, 16'sh0000, 1'b0);
        queue_item(snt_pkg::OpLoad, 5'd2, 16'sd1000, 16'sh0000, 1'b0);
        queue_item(snt_pkg::OpAdjust, 5'd0, 16'sh0000, 16'sh0000, 1'b0);
        queue_item(snt_pkg::OpTrain, 5'd0, -16'sd4096, 16'sd4096, 1'b0);
        queue_item(snt_pkg::OpTrain, 5'd0, 16'sd777, 16'sd0, 1'b1);
        queue_item(snt_pkg::OpTrain, 5'd0, 16'sd300, 16'sh7fff, 1'b1);
        queue_item(snt_pkg::OpTrain, 5'd0, 16'sd0, -16'sd32768, 1'b1);
        queue_item(snt_pkg::OpAdjust, 5'd0, 16'sh0000, 16'sh0000, 1'b0);
        queue_item(snt_pkg::OpForward, 5'd0, 16'sd0, 16'sd0, 1'b1);
        settle();

        // Default rate, with one long receiver hold-off while items keep coming.
        hold_go = 1'b1;
        queue_random(50);
        settle();

        write_rate(16'hffff);
        queue_random(45);
        settle();

        write_rate(16'h0000);
        queue_random(25);
        settle();

        // Last phase: random rate and no idling on either side.
        write_rate(16'($urandom()));
        quiet = 1'b1;
        queue_random(45);
        settle();

        $display("Covered %0d input transfers (%0d train vectors, %0d adjusts with samples),",
                 items_accepted, trains_done, adjusts_done);
        $display("checked %0d results across four learning rates.", results_checked);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/snt_pkg.sv
hdl/snt_divider.sv
hdl/sigmoid_neuron_trainer.sv
sim/tb_top.sv
